// ===== hdl/sida_pkg.sv =====
// ----------------------------------------------------------------------------
// sida_pkg
// Shared constants and types for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sida_pkg;

  // Default width of the converted integer.
  localparam int VALUE_BITS_DEF     = 32;
  // Default number of magnitude bits folded into the BCD value per stage.
  localparam int BITS_PER_STAGE_DEF = 8;

  localparam int CHAR_W = 6;

  // Character codes, truncated to the six bits carried on the result port.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  // Control bits that travel with each request down the pipeline.
  typedef struct packed {
    logic vld;
    logic neg;
  } sida_ctl_t;

endpackage

// ===== hdl/signed_int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed two's-complement integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage: drive in_value and raise start; the request is taken at a clock edge
// where start is high and busy is low. The core answers with a run of
// characters on out_char_code, most significant first, each shown for exactly
// one cycle with out_strobe high. A negative value begins with a minus sign,
// zero gives a single '0', and out_is_last marks the final character of the
// run. The most negative value prints through its unsigned magnitude.
//
// The request passes a capture stage, a negate stage, one
// shift-and-add-3 stage per BITS_PER_STAGE magnitude bits, a leading-digit
// stage and the serializer, which registers out_strobe and the character.
// Throughput: the serializer sends one character per cycle; the text of a
// request has 1 to 11 characters at the default width. Several requests can
// sit in the conversion stages meanwhile; busy rises when the serializer
// still has characters after the current one and the stage in front of it
// is full, and the whole pipeline then holds.
//
// Reset (rst_n low, synchronous) clears every valid bit; requests in flight
// are dropped and no strobe follows. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
  import sida_pkg::*;
#(
  parameter int VALUE_BITS     = VALUE_BITS_DEF,
  parameter int BITS_PER_STAGE = BITS_PER_STAGE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_BITS-1:0]  in_value,
  output logic                   out_strobe,
  output logic [CHAR_W-1:0]      out_char_code,
  output logic                   out_is_last
);

  // Decimal digits needed for 2^(VALUE_BITS-1), never fewer and possibly more.
  localparam int NDIG = (VALUE_BITS * 31) / 100 + 1;
  localparam int IDXW = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int BCDW = 4 * NDIG;
  localparam int NST  = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int BINW = NST * BITS_PER_STAGE;

  // Pipeline advance: every stage before the serializer moves unless the
  // leading-digit stage holds a request that the serializer cannot take yet.
  logic en;
  logic emit_ready;

  sida_ctl_t              cap_ctl_r;
  logic [VALUE_BITS-1:0]  cap_val_r;
  sida_ctl_t              mag_ctl_r;
  logic [VALUE_BITS-1:0]  mag_r, mag_nxt;

  sida_ctl_t              ctl_s [NST+1];
  logic [BCDW-1:0]        bcd_s [NST+1];
  logic [BINW-1:0]        bin_s [NST+1];

  sida_ctl_t              lead_ctl;
  logic [BCDW-1:0]        lead_bcd;
  logic [IDXW-1:0]        lead_idx;

  assign en   = !lead_ctl.vld || emit_ready;
  assign busy = !en;

  // Capture stage: take the request and note the sign.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_ctl_r <= '0;
    end else if (en) begin
      cap_ctl_r.vld <= start;
      cap_ctl_r.neg <= in_value[VALUE_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cap_val_r <= in_value;
    end
  end

  // Magnitude stage: the negate wraps modulo 2^VALUE_BITS, which makes the
  // most negative value come out as its exact unsigned magnitude.
  assign mag_nxt = cap_ctl_r.neg ? (~cap_val_r + VALUE_BITS'(1)) : cap_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_ctl_r <= '0;
    end else if (en) begin
      mag_ctl_r <= cap_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
    end
  end

  assign ctl_s[0] = mag_ctl_r;
  assign bcd_s[0] = '0;
  assign bin_s[0] = BINW'(mag_r);

  // Binary to BCD, BITS_PER_STAGE magnitude bits per registered stage.
  for (genvar g = 0; g < NST; g++) begin : g_dabble
    sida_dabble #(
      .BPS  (BITS_PER_STAGE),
      .BINW (BINW),
      .NDIG (NDIG)
    ) u_dabble (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_ctl  (ctl_s[g]),
      .in_bcd  (bcd_s[g]),
      .in_bin  (bin_s[g]),
      .out_ctl (ctl_s[g+1]),
      .out_bcd (bcd_s[g+1]),
      .out_bin (bin_s[g+1])
    );
  end

  sida_lead #(
    .NDIG (NDIG),
    .IDXW (IDXW)
  ) u_lead (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_ctl   (ctl_s[NST]),
    .in_bcd   (bcd_s[NST]),
    .out_ctl  (lead_ctl),
    .out_bcd  (lead_bcd),
    .out_lead (lead_idx)
  );

  // The serializer loads a new number in the cycle it sends the last
  // character of the previous one, so runs follow without a gap.
  sida_emit #(
    .NDIG (NDIG),
    .IDXW (IDXW)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ctl        (lead_ctl),
    .in_bcd        (lead_bcd),
    .in_lead       (lead_idx),
    .ready         (emit_ready),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

endmodule

// ===== hdl/sida_dabble.sv =====
// ----------------------------------------------------------------------------
// sida_dabble
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
// ----------------------------------------------------------------------------
module sida_dabble
  import sida_pkg::*;
#(
  parameter int BPS  = BITS_PER_STAGE_DEF,
  parameter int BINW = VALUE_BITS_DEF,
  parameter int NDIG = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  sida_ctl_t           in_ctl,
  input  logic [4*NDIG-1:0]   in_bcd,
  input  logic [BINW-1:0]     in_bin,
  output sida_ctl_t           out_ctl,
  output logic [4*NDIG-1:0]   out_bcd,
  output logic [BINW-1:0]     out_bin
);

  localparam int BCDW = 4 * NDIG;

  sida_ctl_t         ctl_r;
  logic [BCDW-1:0]   bcd_r, bcd_nxt;
  logic [BINW-1:0]   bin_r, bin_nxt;

  // Fold the next BPS magnitude bits, most significant first, into the digits.
  always_comb begin
    bcd_nxt = in_bcd;
    bin_nxt = in_bin;
    for (int b = 0; b < BPS; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_nxt[4*d +: 4] >= 4'd5) begin
          bcd_nxt[4*d +: 4] = bcd_nxt[4*d +: 4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[BCDW-2:0], bin_nxt[BINW-1]};
      bin_nxt = {bin_nxt[BINW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bcd_r <= bcd_nxt;
      bin_r <= bin_nxt;
    end
  end

  assign out_ctl = ctl_r;
  assign out_bcd = bcd_r;
  assign out_bin = bin_r;

endmodule

// ===== hdl/sida_lead.sv =====
// ----------------------------------------------------------------------------
// sida_lead
// Pipeline stage that finds the most significant nonzero decimal digit.
// ----------------------------------------------------------------------------
module sida_lead
  import sida_pkg::*;
#(
  parameter int NDIG = 10,
  parameter int IDXW = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  sida_ctl_t          in_ctl,
  input  logic [4*NDIG-1:0]  in_bcd,
  output sida_ctl_t          out_ctl,
  output logic [4*NDIG-1:0]  out_bcd,
  output logic [IDXW-1:0]    out_lead
);

  sida_ctl_t          ctl_r;
  logic [4*NDIG-1:0]  bcd_r;
  logic [IDXW-1:0]    lead_r, lead_nxt;

  // Zero keeps index 0, so it prints as a single digit.
  always_comb begin
    lead_nxt = '0;
    for (int d = 1; d < NDIG; d++) begin
      if (in_bcd[4*d +: 4] != 4'd0) begin
        lead_nxt = IDXW'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bcd_r  <= in_bcd;
      lead_r <= lead_nxt;
    end
  end

  assign out_ctl  = ctl_r;
  assign out_bcd  = bcd_r;
  assign out_lead = lead_r;

endmodule

// ===== hdl/sida_emit.sv =====
// ----------------------------------------------------------------------------
// sida_emit
// Serializer that sends one character per cycle from a converted number.
// ----------------------------------------------------------------------------
module sida_emit
  import sida_pkg::*;
#(
  parameter int NDIG = 10,
  parameter int IDXW = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sida_ctl_t          in_ctl,
  input  logic [4*NDIG-1:0]  in_bcd,
  input  logic [IDXW-1:0]    in_lead,
  output logic               ready,
  output logic               out_strobe,
  output logic [CHAR_W-1:0]  out_char_code,
  output logic               out_is_last
);

  logic               act_r;
  logic               neg_r;
  logic [IDXW-1:0]    idx_r;
  logic [4*NDIG-1:0]  bcd_r;
  logic               strobe_r;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic               last_r, last_nxt;
  logic               load;

  // The current character is the last one when the sign is sent and the
  // lowest digit is up.
  assign last_nxt = act_r && !neg_r && (idx_r == '0);
  assign ready    = !act_r || last_nxt;
  assign load     = in_ctl.vld && ready;

  always_comb begin
    if (neg_r) begin
      char_nxt = CHAR_MINUS;
    end else begin
      char_nxt = CHAR_ZERO + CHAR_W'(bcd_r[4*idx_r +: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 1'b0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      strobe_r <= act_r;
      last_r   <= last_nxt;
      if (load) begin
        act_r <= 1'b1;
      end else if (ready) begin
        act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    if (load) begin
      neg_r <= in_ctl.neg;
      idx_r <= in_lead;
      bcd_r <= in_bcd;
    end else if (act_r) begin
      if (neg_r) begin
        neg_r <= 1'b0;
      end else if (idx_r != '0) begin
        idx_r <= idx_r - IDXW'(1);
      end
    end
  end

  assign out_strobe    = strobe_r;
  assign out_char_code = char_r;
  assign out_is_last   = last_r;

endmodule

// ===== hdl/sida_checker.sv =====
// ----------------------------------------------------------------------------
// sida_checker
// Port-level checks on the character stream of the decimal text core.
// ----------------------------------------------------------------------------
module sida_checker
  import sida_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_strobe,
  input logic [CHAR_W-1:0]  out_char_code,
  input logic               out_is_last
);

  // No character appears in the cycle after a reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("strobe right after reset");

  // Every character is a minus sign or a digit.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_char_code == CHAR_MINUS) ||
                   ((out_char_code >= CHAR_ZERO) && (out_char_code <= CHAR_NINE)))
    else $error("character outside the minus sign and digits");

  // A minus sign never ends a run and is followed at once by a digit.
  a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_char_code == CHAR_MINUS)) |->
      !out_is_last ##1 (out_strobe && (out_char_code != CHAR_MINUS)))
    else $error("minus sign not followed by a digit");

  // A run that is not finished continues in the next cycle.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_is_last) |=> out_strobe)
    else $error("character run broken before its last mark");

endmodule

bind signed_int_to_decimal_ascii_core sida_checker u_sida_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_strobe    (out_strobe),
  .out_char_code (out_char_code),
  .out_is_last   (out_is_last)
);
